// ===== sv/oversampled_tube_distortion_macros.svh =====
// Assertion macros shared by the block.
`ifndef OVERSAMPLED_TUBE_DISTORTION_MACROS_SVH
`define OVERSAMPLED_TUBE_DISTORTION_MACROS_SVH

// A same-cycle implication checked at every clock edge outside reset.
`define OTD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// A next-cycle implication checked at every clock edge outside reset.
`define OTD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/otd_pkg.sv =====
`default_nettype none
package otd_pkg;
  localparam int CHANNELS_DEF = 2;
  localparam int SW = 24;
  localparam int DW = 18;
  localparam int MW = 34;
  localparam int MBITS = 48;
  localparam logic [DW-1:0] DRIVE_RESET = 18'd40960;
  localparam logic [DW-1:0] DRIVE_MAX = 18'd131072;
  localparam logic signed [MW-1:0] HP_COEF = 34'sd32113;
  localparam logic signed [MW-1:0] LP_COEF = 34'sd12000;
  localparam logic signed [MW-1:0] THR_POS = 34'sd1200000;
  localparam logic signed [MW-1:0] THR_NEG = -34'sd900000;
  localparam logic signed [MW-1:0] S24_MAX = 34'sd8388607;
  localparam logic signed [MW-1:0] S24_MIN = -34'sd8388608;
  localparam logic signed [MW-1:0] S32_MAX = 34'sd2147483647;
  localparam logic signed [MW-1:0] S32_MIN = -34'sd2147483648;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_HP   = 7'b0000010,
    ST_DRV  = 7'b0000100,
    ST_CLIP = 7'b0001000,
    ST_LP   = 7'b0010000,
    ST_FIN  = 7'b0100000,
    ST_OUT  = 7'b1000000
  } state_t;

  typedef struct packed {
    logic start;
    logic busy;
  } mul_ctl_t;

  function automatic logic signed [MW-1:0] sat(
    input logic signed [MW-1:0] v, input logic signed [MW-1:0] lo,
    input logic signed [MW-1:0] hi);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic logic signed [MW-1:0] knee(input logic signed [MW-1:0] x);
    if (x > THR_POS) return THR_POS + ((x - THR_POS) >>> 10);
    if (x < THR_NEG) return THR_NEG + ((x - THR_NEG) >>> 10);
    return x;
  endfunction
endpackage
`default_nettype wire

// ===== sv/oversampled_tube_distortion.sv =====
`default_nettype none
// Channel  Ports                          Direction
// in       in_valid/in_ready, fields      input beat
// out      out_valid/out_ready, field     result beat
// cfg      cfg_we/cfg_wdata               register write
// A beat is accepted, then passes the high-pass, drive, clip, low-pass and final states
// before its result is offered. Three products go through one bit-serial multiplier.
// Reset clears filter state and sets the drive to its default.
// A result waits in its output register; the next beat is taken once the
// result has gone.
module oversampled_tube_distortion #(
  parameter int CHANNELS = otd_pkg::CHANNELS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic signed [otd_pkg::SW-1:0]  in_sample_in,
  input  wire logic                           in_channel,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic signed [otd_pkg::SW-1:0]       out_sample_out,
  input  wire logic                           cfg_we,
  input  wire logic [otd_pkg::DW-1:0]         cfg_wdata
);
  import otd_pkg::*;
  `include "oversampled_tube_distortion_macros.svh"
  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic signed [SW-1:0] pin_r [CHANNELS];
  logic signed [31:0] php_r [CHANNELS], pdr_r [CHANNELS], plp_r [CHANNELS];
  logic [DW-1:0] drive_r;
  state_t st_r, st_nxt;
  logic [CW-1:0] ch_r;
  logic signed [SW-1:0] x_r;
  logic signed [MW-1:0] hp_r, d_r, y_r, opa;
  logic [DW-1:0] opb;
  logic signed [SW-1:0] res_r;
  logic go_r;
  mul_ctl_t ctl;
  logic mdone;
  logic signed [MBITS-1:0] prod;
  logic signed [MW-1:0] mid, y0, y1;
  logic signed [MBITS-1:0] hps, lps, dsh;
  logic [CW-1:0] chsel;

  assign chsel = (CHANNELS == 1) ? '0 :
                 ((32'(in_channel) >= CHANNELS) ? CW'(CHANNELS - 1) : CW'(in_channel));
  assign in_ready = st_r == ST_IDLE;
  assign out_valid = st_r == ST_OUT;
  assign out_sample_out = res_r;
  assign ctl.start = go_r;
  assign ctl.busy = !(st_r == ST_IDLE || st_r == ST_OUT);

  always_comb begin
    unique case (st_r)
      ST_DRV:  begin opa = hp_r; opb = drive_r; end
      ST_LP:   begin opa = y_r - MW'(plp_r[ch_r]); opb = DW'(LP_COEF); end
      default: begin opa = MW'(php_r[ch_r]); opb = DW'(HP_COEF); end
    endcase
  end

  otd_mul u_mul (.clk(clk), .rst_n(rst_n), .ctl(ctl), .a(opa), .b(opb),
    .done(mdone), .p(prod));

  assign hps = MBITS'(x_r) - MBITS'(pin_r[ch_r]) + (prod >>> 15);
  assign dsh = prod >>> 8;
  assign mid = (d_r + MW'(pdr_r[ch_r])) >>> 1;
  assign y0 = knee(sat(d_r, S24_MIN, S24_MAX));
  assign y1 = knee(sat(mid, S24_MIN, S24_MAX));
  assign lps = MBITS'(plp_r[ch_r]) + (prod >>> 15);

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (in_valid) st_nxt = ST_HP;
      ST_HP:   if (mdone) st_nxt = ST_DRV;
      ST_DRV:  if (mdone) st_nxt = ST_CLIP;
      ST_CLIP: st_nxt = ST_LP;
      ST_LP:   if (mdone) st_nxt = ST_FIN;
      ST_FIN:  st_nxt = ST_OUT;
      ST_OUT:  if (out_ready) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      go_r <= 1'b0;
      drive_r <= DRIVE_RESET;
      for (int i = 0; i < CHANNELS; i++) begin
        pin_r[i] <= '0; php_r[i] <= '0; pdr_r[i] <= '0; plp_r[i] <= '0;
      end
    end else begin
      st_r <= st_nxt;
      go_r <= 1'b0;
      if (cfg_we) drive_r <= (cfg_wdata > DRIVE_MAX) ? DRIVE_MAX : cfg_wdata;
      unique case (st_r)
        ST_IDLE: if (in_valid) begin
          x_r <= in_sample_in; ch_r <= chsel; go_r <= 1'b1;
        end
        ST_HP: if (mdone) begin
          hp_r <= MW'(signed'(hps[31:0]));
          php_r[ch_r] <= hps[31:0];
          pin_r[ch_r] <= x_r;
          go_r <= 1'b1;
        end
        ST_DRV: if (mdone) d_r <= (dsh > MBITS'(S32_MAX)) ? S32_MAX :
                                  ((dsh < MBITS'(S32_MIN)) ? S32_MIN : MW'(dsh));
        ST_CLIP: begin
          y_r <= (y0 + y1) >>> 1;
          pdr_r[ch_r] <= d_r[31:0];
          go_r <= 1'b1;
        end
        ST_LP: if (mdone) begin
          plp_r[ch_r] <= lps[31:0];
          y_r <= MW'(signed'(lps[31:0]));
        end
        ST_FIN: res_r <= SW'(sat(y_r, S24_MIN, S24_MAX));
        default: ;
      endcase
    end
  end

  `OTD_ASSERT_NEXT(a_go_once, clk, rst_n, go_r, !go_r, "multiplier started twice")
  `OTD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
    out_valid && $stable(out_sample_out), "result dropped")
  `OTD_ASSERT_IMP(a_done_busy, clk, rst_n, mdone, ctl.busy, "done while idle")
endmodule
`default_nettype wire

// ===== sv/otd_mul.sv =====
`default_nettype none
// Shift-and-add multiplier: one bit of the unsigned multiplier per cycle.
module otd_mul (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire otd_pkg::mul_ctl_t               ctl,
  input  wire logic signed [otd_pkg::MW-1:0]   a,
  input  wire logic [otd_pkg::DW-1:0]          b,
  output logic                                 done,
  output logic signed [otd_pkg::MBITS-1:0]     p
);
  import otd_pkg::*;
  logic signed [MBITS-1:0] acc_r, acc_nxt, mc_r, mc_nxt;
  logic [DW-1:0] mp_r, mp_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic run_r, run_nxt;

  always_comb begin
    acc_nxt = acc_r; mc_nxt = mc_r; mp_nxt = mp_r; cnt_nxt = cnt_r; run_nxt = run_r;
    if (ctl.start) begin
      acc_nxt = '0;
      mc_nxt = MBITS'(a);
      mp_nxt = b;
      cnt_nxt = 5'(DW);
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (mp_r[0]) acc_nxt = acc_r + mc_r;
      mc_nxt = mc_r <<< 1;
      mp_nxt = mp_r >> 1;
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) run_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      run_r <= run_nxt;
      cnt_r <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    mc_r <= mc_nxt;
    mp_r <= mp_nxt;
  end

  assign done = run_r && (cnt_r == 5'd1) && !ctl.start;
  assign p = (mp_r[0]) ? acc_r + mc_r : acc_r;
endmodule
`default_nettype wire
